[sv/pcbs_pkg.sv]
// ---------------------------------------------------------------------------
// Pulse command board supervisor package
// Shared types, command boundaries and result codes.
// ---------------------------------------------------------------------------
package pcbs_pkg;

  localparam int unsigned SecW  = 10;
  localparam int unsigned TickW = 13;
  localparam int unsigned CntW  = 8;

  localparam logic [CntW-1:0] CmdMin    = 8'd4;
  localparam logic [CntW-1:0] CmdWdtOff = 8'd20;
  localparam logic [CntW-1:0] CmdReset  = 8'd30;
  localparam logic [CntW-1:0] CmdCycle  = 8'd40;
  localparam logic [CntW-1:0] CmdShort  = 8'd50;
  localparam logic [CntW-1:0] CmdLong   = 8'd60;
  localparam logic [CntW-1:0] CmdEnd    = 8'd70;
  localparam logic [CntW-1:0] CntMax    = 8'd255;
  localparam logic [SecW-1:0] SilentMax = 10'd1023;

  localparam logic [2:0] CyclesCommand  = 3'd7;
  localparam logic [2:0] CyclesWatchdog = 3'd5;
  localparam logic [2:0] CyclesSilence  = 3'd3;

  localparam logic [SecW-1:0]  WdtTimeoutRst = 10'd15;
  localparam logic [SecW-1:0]  SilTimeoutRst = 10'd453;
  localparam logic [TickW-1:0] TicksPerSecRst = 13'd6776;
  localparam logic [TickW-1:0] FeedTickRst   = 13'd61;

  typedef enum logic [1:0] {
    REG_WDT_TIMEOUT = 2'd0,
    REG_SIL_TIMEOUT = 2'd1,
    REG_TICKS_PER_S = 2'd2,
    REG_FEED_TICK   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_RESET = 3'd1,
    ACT_CYCLE = 3'd2,
    ACT_SHORT = 3'd3,
    ACT_LONG  = 3'd4
  } action_e;

  typedef struct packed {
    logic [SecW-1:0]  wdt_timeout;
    logic [SecW-1:0]  sil_timeout;
    logic [TickW-1:0] ticks_per_s;
    logic [TickW-1:0] feed_tick;
  } cfg_t;

  typedef struct packed {
    logic       startup_flag;
    logic       led_toggle;
    logic       feed_toggle;
    logic [2:0] power_cycles;
    action_e    action;
  } result_t;

endpackage

[sv/pcbs_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the four timing registers written through the plain write port.
// ---------------------------------------------------------------------------
module pcbs_cfg_regs
  import pcbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wdt_timeout <= WdtTimeoutRst;
      cfg_q.sil_timeout <= SilTimeoutRst;
      cfg_q.ticks_per_s <= TicksPerSecRst;
      cfg_q.feed_tick   <= FeedTickRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_WDT_TIMEOUT: cfg_q.wdt_timeout <= cfg_wdata_i[SecW-1:0];
        REG_SIL_TIMEOUT: cfg_q.sil_timeout <= cfg_wdata_i[SecW-1:0];
        REG_TICKS_PER_S: cfg_q.ticks_per_s <= cfg_wdata_i;
        REG_FEED_TICK:   cfg_q.feed_tick   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/pcbs_core.sv]
// ---------------------------------------------------------------------------
// Supervisor core
// Per-tick state update: frame decode, edge counting, seconds and timeouts.
// ---------------------------------------------------------------------------
module pcbs_core
  import pcbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    cs_i,
  input  logic    data_i,
  input  logic    debug_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic            cs_prev_q, cs_prev_d;
  logic            data_prev_q, data_prev_d;
  logic            rcv_q, rcv_d;
  logic [CntW-1:0] edge_cnt_q, edge_cnt_d;
  logic [CntW-1:0] cmd_q, cmd_d;
  logic            wd_en_q, wd_en_d;
  logic            alive_q, alive_d;
  logic [SecW-1:0] silent_q, silent_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic            startup_q, startup_d;

  always_comb begin
    cs_prev_d   = cs_i;
    data_prev_d = data_i;
    rcv_d       = rcv_q;
    edge_cnt_d  = edge_cnt_q;
    cmd_d       = cmd_q;
    wd_en_d     = wd_en_q;
    alive_d     = alive_q;
    silent_d    = silent_q;
    startup_d   = startup_q;
    res_o       = '0;
    res_o.action = ACT_NONE;

    // select edge: falling opens a frame, rising latches the count
    if (cs_i != cs_prev_q) begin
      if (cs_prev_q) begin
        rcv_d = 1'b1;
      end else begin
        rcv_d      = 1'b0;
        cmd_d      = edge_cnt_q;
        edge_cnt_d = '0;
      end
    end

    if (data_i != data_prev_q) begin
      if (rcv_d) begin
        if (data_prev_q) begin
          if (edge_cnt_d != CntMax) edge_cnt_d = edge_cnt_d + 1'b1;
          if (!startup_q) res_o.led_toggle = 1'b1;
        end
      end else begin
        edge_cnt_d = '0;
      end
    end

    tick_d = tick_q + 1'b1;
    if (tick_d == cfg_i.ticks_per_s) begin
      if (silent_d != SilentMax) silent_d = silent_d + 1'b1;
      tick_d = '0;
    end else if (tick_d == cfg_i.feed_tick) begin
      res_o.feed_toggle = 1'b1;
    end

    if (!debug_i) silent_d = '0;

    if (cmd_d >= CmdMin) begin
      startup_d = 1'b0;
      silent_d  = '0;
      if (cmd_d < CmdEnd) alive_d = 1'b1;
      if (cmd_d < CmdWdtOff) begin
        wd_en_d = 1'b1;
      end else if (cmd_d < CmdReset) begin
        wd_en_d = 1'b0;
      end else if (cmd_d < CmdCycle) begin
        wd_en_d      = 1'b0;
        res_o.action = ACT_RESET;
      end else if (cmd_d < CmdShort) begin
        wd_en_d            = 1'b0;
        res_o.action       = ACT_CYCLE;
        res_o.power_cycles = CyclesCommand;
        startup_d          = 1'b1;
      end else if (cmd_d < CmdLong) begin
        res_o.action = ACT_SHORT;
      end else if (cmd_d < CmdEnd) begin
        res_o.action = ACT_LONG;
      end
      cmd_d = '0;
    end

    if (wd_en_d) alive_d = !(silent_d > cfg_i.wdt_timeout);

    if (!alive_d && wd_en_d) begin
      wd_en_d            = 1'b0;
      silent_d           = '0;
      res_o.action       = ACT_CYCLE;
      res_o.power_cycles = CyclesWatchdog;
      startup_d          = 1'b1;
    end

    if (silent_d > cfg_i.sil_timeout) begin
      silent_d           = '0;
      res_o.action       = ACT_CYCLE;
      res_o.power_cycles = CyclesSilence;
      startup_d          = 1'b1;
    end

    res_o.startup_flag = startup_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_prev_q   <= 1'b0;
      data_prev_q <= 1'b0;
      rcv_q       <= 1'b0;
      edge_cnt_q  <= '0;
      cmd_q       <= '0;
      wd_en_q     <= 1'b0;
      alive_q     <= 1'b1;
      silent_q    <= '0;
      tick_q      <= '0;
      startup_q   <= 1'b0;
    end else if (step_i) begin
      cs_prev_q   <= cs_prev_d;
      data_prev_q <= data_prev_d;
      rcv_q       <= rcv_d;
      edge_cnt_q  <= edge_cnt_d;
      cmd_q       <= cmd_d;
      wd_en_q     <= wd_en_d;
      alive_q     <= alive_d;
      silent_q    <= silent_d;
      tick_q      <= tick_d;
      startup_q   <= startup_d;
    end
  end

endmodule

[sv/pcbs_out_buf.sv]
// ---------------------------------------------------------------------------
// Result buffer
// Two-entry result queue that decouples the core from downstream stalls.
// ---------------------------------------------------------------------------
module pcbs_out_buf
  import pcbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign res_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/pulse_command_board_supervisor.sv]
// ---------------------------------------------------------------------------
// Pulse command board supervisor
// Decodes pulse-counted commands and watches host silence, one tick per beat.
// ---------------------------------------------------------------------------
// Path: the input beat is held in the input register, then the state update
//   writes its result into the result queue.
// Throughput: 1 beat per cycle while the result queue has space; the two-entry result queue absorbs stalls.
// Reset: asynchronous, active low; clears control and core state, loads register defaults.
module pulse_command_board_supervisor
  import pcbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] cs_level, [1] data_level, [2] debug_level
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [2:0] action, [5:3] power_cycles,
                                           // [6] feed_toggle, [7] led_toggle, [8] startup_flag
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [TickW-1:0] cfg_wdata_i
);

  cfg_t       cfg;
  result_t    res_core, res_out;
  logic       in_v_q;
  logic [2:0] in_q;
  logic       space, advance;

  pcbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance       = in_v_q && space;
  assign s_axis_tready = !in_v_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= s_axis_tdata[2:0];
  end

  pcbs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .cs_i    (in_q[0]),
    .data_i  (in_q[1]),
    .debug_i (in_q[2]),
    .cfg_i   (cfg),
    .res_o   (res_core)
  );

  pcbs_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance),
    .res_i   (res_core),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {7'd0, res_out};

endmodule

[sv/pcbs_checker.sv]
// ---------------------------------------------------------------------------
// Supervisor port checker
// Port-level checks on result beats, bound to the top level.
// ---------------------------------------------------------------------------
module pcbs_checker
  import pcbs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a power cycle count appears only with a power cycle action
  a_cycles_need_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[5:3] != 3'd0) |-> m_axis_tdata[2:0] == ACT_CYCLE)
    else $error("power_cycles set without power cycle action");

  a_cycles_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == ACT_CYCLE |->
      m_axis_tdata[5:3] == CyclesCommand || m_axis_tdata[5:3] == CyclesWatchdog ||
      m_axis_tdata[5:3] == CyclesSilence)
    else $error("illegal power cycle count");

  // every power cycle leaves the board in startup
  a_cycle_sets_startup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == ACT_CYCLE |-> m_axis_tdata[8])
    else $error("power cycle without startup flag");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ACT_LONG && m_axis_tdata[15:9] == 7'd0)
    else $error("action code out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind pulse_command_board_supervisor pcbs_checker u_pcbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
